>>> hdl/clcd_pkg.sv
`timescale 1ns / 1ps

package clcd_pkg;

  // Character store geometry.
  localparam int CHAR_DEPTH = 32;
  localparam int CHAR_AW    = $clog2(CHAR_DEPTH);

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_POWER_ON_WAIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FUNCTION_SET  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_ON    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_MODE    = 3'd4;

  localparam logic [7:0] RST_POWER_ON_WAIT = 8'd30;
  localparam logic [7:0] RST_FUNCTION_SET  = 8'd56;
  localparam logic [7:0] RST_DISPLAY_ON    = 8'd15;
  localparam logic [7:0] RST_CLEAR         = 8'd1;
  localparam logic [7:0] RST_ENTRY_MODE    = 8'd6;

  // Item kinds.
  localparam logic [2:0] MODE_TICK    = 3'd0;
  localparam logic [2:0] MODE_CURSOR  = 3'd1;
  localparam logic [2:0] MODE_COMMAND = 3'd2;
  localparam logic [2:0] MODE_STRING  = 3'd3;
  localparam logic [2:0] MODE_LOAD    = 3'd4;

  // Display phase.
  localparam logic [1:0] PH_INIT = 2'd0;
  localparam logic [1:0] PH_OPER = 2'd1;
  localparam logic [1:0] PH_OFF  = 2'd2;

  // Initialisation steps.
  localparam logic [2:0] ST_WAIT  = 3'd0;
  localparam logic [2:0] ST_FSET  = 3'd1;
  localparam logic [2:0] ST_DISP  = 3'd2;
  localparam logic [2:0] ST_CLR   = 3'd3;
  localparam logic [2:0] ST_ENTRY = 3'd4;
  localparam logic [2:0] ST_END   = 3'd5;

  // Request kinds.
  localparam logic [1:0] RQ_CURSOR  = 2'd0;
  localparam logic [1:0] RQ_STRING  = 2'd1;
  localparam logic [1:0] RQ_COMMAND = 2'd2;
  localparam logic [1:0] RQ_NONE    = 2'd3;

  localparam logic [7:0] ROW1_BASE = 8'h80;
  localparam logic [7:0] ROW2_BASE = 8'hC0;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] row;
    logic [7:0] column;
    logic [7:0] command_byte;
    logic [5:0] string_length;
    logic [4:0] char_index;
    logic [7:0] char_value;
  } item_t;

  // State after one item, handed to the output stage.
  typedef struct packed {
    logic       data_we;   // data lines take data
    logic       data_ram;  // data lines take the store read data
    logic [7:0] data;
    logic       rs;
    logic       en;
    logic [1:0] phase;
    logic       busy;
    logic       taken;
  } upd_t;

  typedef struct packed {
    logic               we;
    logic [CHAR_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic               re;
    logic [CHAR_AW-1:0] raddr;
  } ram_req_t;

endpackage

>>> hdl/clcd_ram.sv
`timescale 1ns / 1ps

module clcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/clcd_ctrl.sv
`timescale 1ns / 1ps

module clcd_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [clcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clcd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           acc,
  input  clcd_pkg::item_t                item,
  output clcd_pkg::upd_t                 upd,
  output clcd_pkg::ram_req_t             ram
);

  logic [7:0] pow_wait_r, fset_r, disp_r, clr_r, entry_r;

  logic [1:0] phase_r, phase_nxt;
  logic [2:0] step_r, step_nxt;
  logic [7:0] tick_r, tick_nxt;
  logic       busy_r, busy_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [7:0] pcmd_r, pcmd_nxt;
  logic [1:0] crow_r, crow_nxt;
  logic [7:0] ccol_r, ccol_nxt;
  logic [5:0] left_r, left_nxt;
  logic [clcd_pkg::CHAR_AW-1:0] pos_r, pos_nxt;
  logic       rs_r, rs_nxt;
  logic       en_r, en_nxt;

  logic [7:0] tick_inc;
  logic [7:0] col_off;
  logic [7:0] init_cmd;
  logic       ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pow_wait_r <= clcd_pkg::RST_POWER_ON_WAIT;
      fset_r     <= clcd_pkg::RST_FUNCTION_SET;
      disp_r     <= clcd_pkg::RST_DISPLAY_ON;
      clr_r      <= clcd_pkg::RST_CLEAR;
      entry_r    <= clcd_pkg::RST_ENTRY_MODE;
    end else if (cfg_we) begin
      case (cfg_index)
        clcd_pkg::REG_POWER_ON_WAIT: pow_wait_r <= cfg_data;
        clcd_pkg::REG_FUNCTION_SET:  fset_r     <= cfg_data;
        clcd_pkg::REG_DISPLAY_ON:    disp_r     <= cfg_data;
        clcd_pkg::REG_CLEAR:         clr_r      <= cfg_data;
        clcd_pkg::REG_ENTRY_MODE:    entry_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign tick_inc = tick_r + 8'd1;
  assign col_off  = ccol_r - 8'd1;
  assign ready    = !busy_r && (phase_r == clcd_pkg::PH_OPER);

  always_comb begin
    case (step_r)
      clcd_pkg::ST_FSET: init_cmd = fset_r;
      clcd_pkg::ST_DISP: init_cmd = disp_r;
      clcd_pkg::ST_CLR:  init_cmd = clr_r;
      default:           init_cmd = entry_r;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    step_nxt  = step_r;
    tick_nxt  = tick_r;
    busy_nxt  = busy_r;
    kind_nxt  = kind_r;
    pcmd_nxt  = pcmd_r;
    crow_nxt  = crow_r;
    ccol_nxt  = ccol_r;
    left_nxt  = left_r;
    pos_nxt   = pos_r;
    rs_nxt    = rs_r;
    en_nxt    = en_r;
    upd       = '0;
    upd.data  = pcmd_r;
    ram       = '0;
    ram.waddr = item.char_index;
    ram.wdata = item.char_value;
    ram.raddr = pos_r;

    case (item.mode)
      clcd_pkg::MODE_TICK: begin
        if (phase_r == clcd_pkg::PH_INIT) begin
          tick_nxt = tick_inc;
          case (step_r)
            clcd_pkg::ST_WAIT: begin
              if (tick_inc >= pow_wait_r) begin
                step_nxt = clcd_pkg::ST_FSET;
                tick_nxt = '0;
              end
            end
            clcd_pkg::ST_FSET, clcd_pkg::ST_DISP,
            clcd_pkg::ST_CLR, clcd_pkg::ST_ENTRY: begin
              if (tick_inc == 8'd2) begin
                upd.data_we = 1'b1;
                upd.data    = init_cmd;
                rs_nxt      = 1'b0;
                en_nxt      = 1'b1;
              end else if (tick_inc > 8'd2) begin
                en_nxt   = 1'b0;
                step_nxt = step_r + 3'd1;
                tick_nxt = '0;
              end
            end
            clcd_pkg::ST_END: begin
              phase_nxt = clcd_pkg::PH_OPER;
              busy_nxt  = 1'b0;
              tick_nxt  = '0;
            end
            default: ;
          endcase
        end else if (phase_r == clcd_pkg::PH_OPER) begin
          tick_nxt = tick_inc;
          case (kind_r)
            clcd_pkg::RQ_STRING: begin
              if (left_r != '0) begin
                if (tick_inc[0]) begin
                  // The character comes out of the store's registered read, alongside this item's result.
                  ram.re       = 1'b1;
                  upd.data_ram = 1'b1;
                  rs_nxt       = 1'b1;
                  en_nxt       = 1'b1;
                end else begin
                  en_nxt   = 1'b0;
                  pos_nxt  = pos_r + 1'b1;
                  left_nxt = left_r - 6'd1;
                end
              end else begin
                left_nxt = '0;
                pos_nxt  = '0;
                busy_nxt = 1'b0;
                kind_nxt = clcd_pkg::RQ_NONE;
                tick_nxt = '0;
              end
            end
            clcd_pkg::RQ_CURSOR: begin
              if (tick_inc == 8'd1) begin
                if (crow_r == 2'd1) begin
                  pcmd_nxt = clcd_pkg::ROW1_BASE + col_off;
                end else if (crow_r == 2'd2) begin
                  pcmd_nxt = clcd_pkg::ROW2_BASE + col_off;
                end
                upd.data_we = 1'b1;
                upd.data    = pcmd_nxt;
                rs_nxt      = 1'b0;
                en_nxt      = 1'b1;
              end else if (tick_inc == 8'd2) begin
                en_nxt   = 1'b0;
                busy_nxt = 1'b0;
                kind_nxt = clcd_pkg::RQ_NONE;
                tick_nxt = '0;
              end
            end
            clcd_pkg::RQ_COMMAND: begin
              if (tick_inc == 8'd1) begin
                upd.data_we = 1'b1;
                upd.data    = pcmd_r;
                rs_nxt      = 1'b0;
                en_nxt      = 1'b1;
              end else if (tick_inc == 8'd2) begin
                en_nxt = 1'b0;
              end else if (tick_inc == 8'd4) begin
                busy_nxt = 1'b0;
                kind_nxt = clcd_pkg::RQ_NONE;
                tick_nxt = '0;
              end
            end
            default: tick_nxt = '0;
          endcase
        end
      end
      clcd_pkg::MODE_CURSOR: begin
        if (ready) begin
          busy_nxt  = 1'b1;
          kind_nxt  = clcd_pkg::RQ_CURSOR;
          crow_nxt  = item.row;
          ccol_nxt  = item.column;
          upd.taken = 1'b1;
        end
      end
      clcd_pkg::MODE_COMMAND: begin
        if (ready) begin
          busy_nxt  = 1'b1;
          kind_nxt  = clcd_pkg::RQ_COMMAND;
          pcmd_nxt  = item.command_byte;
          upd.taken = 1'b1;
        end
      end
      clcd_pkg::MODE_STRING: begin
        if (ready) begin
          busy_nxt  = 1'b1;
          kind_nxt  = clcd_pkg::RQ_STRING;
          left_nxt  = item.string_length;
          pos_nxt   = '0;
          upd.taken = 1'b1;
        end
      end
      clcd_pkg::MODE_LOAD: ram.we = 1'b1;
      default: ;
    endcase

    ram.we    = ram.we && acc;
    ram.re    = ram.re && acc;
    upd.rs    = rs_nxt;
    upd.en    = en_nxt;
    upd.phase = phase_nxt;
    upd.busy  = busy_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= clcd_pkg::PH_INIT;
      step_r  <= clcd_pkg::ST_WAIT;
      tick_r  <= '0;
      busy_r  <= 1'b1;
      kind_r  <= clcd_pkg::RQ_NONE;
      pcmd_r  <= '0;
      crow_r  <= '0;
      ccol_r  <= '0;
      left_r  <= '0;
      pos_r   <= '0;
      rs_r    <= 1'b0;
      en_r    <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      tick_r  <= tick_nxt;
      busy_r  <= busy_nxt;
      kind_r  <= kind_nxt;
      pcmd_r  <= pcmd_nxt;
      crow_r  <= crow_nxt;
      ccol_r  <= ccol_nxt;
      left_r  <= left_nxt;
      pos_r   <= pos_nxt;
      rs_r    <= rs_nxt;
      en_r    <= en_nxt;
    end
  end

  // An accepted request must leave the block busy.
  a_taken_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc && upd.taken |=> busy_r)
    else $error("accepted request did not set busy");

  // Busy only clears once initialisation has finished.
  a_idle_oper: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> phase_r == clcd_pkg::PH_OPER)
    else $error("block idle outside the operational phase");

  // The store is only read while characters of a string are still due.
  a_read_string: assert property (@(posedge clk) disable iff (!rst_n)
    ram.re |-> kind_r == clcd_pkg::RQ_STRING && left_r != '0)
    else $error("store read outside a string write");

  // With no request pending, ticks keep the count at zero.
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    acc && item.mode == clcd_pkg::MODE_TICK && phase_r == clcd_pkg::PH_OPER
      && kind_r == clcd_pkg::RQ_NONE |=> tick_r == '0)
    else $error("tick count moved with no request");

endmodule

>>> hdl/char_lcd_timed_interface.sv
`timescale 1ns / 1ps

// Channel   Direction  Group                       Contents
// in_       slave      tvalid tready tdata tuser   one tick, request or store load per item
// out_      master     tvalid tready tdata         pin levels and status after each item
// cfg_      write      we index data               power-on wait and the four init commands
//
// One item is taken every cycle unless the output stalls; each result is registered.
// The character store has a registered read, so a character fetched for a
// string write is folded into the data lines at the output register rather than earlier.
// Reset is synchronous and active low; no clearing pass follows it, the store is simply
// undefined until loaded. A stalled output holds its item while the input waits with it.

module char_lcd_timed_interface (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // row[1:0], column[9:2], command_byte[17:10], string_length[23:18],
  // char_index[28:24], char_value[36:29], zero fill [39:37]
  input  logic [39:0]                     in_tdata,
  // mode[2:0]
  input  logic [2:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // data_pins[7:0], rs_pin[8], enable_pin[9], lcd_phase[11:10],
  // request_busy[12], request_taken[13], zero fill [15:14]
  output logic [15:0]                     out_tdata,
  input  logic                            cfg_we,
  input  logic [clcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clcd_pkg::CFG_DATA_W-1:0] cfg_data
);

  clcd_pkg::item_t    item;
  clcd_pkg::upd_t     upd;
  clcd_pkg::ram_req_t ram;

  logic       accept;
  logic [7:0] ram_rdata;
  logic [7:0] pins_now;

  logic       out_valid_r;
  logic [7:0] data_r;
  logic       ram_sel_r;
  logic       rs_r;
  logic       en_r;
  logic [1:0] phase_r;
  logic       busy_r;
  logic       taken_r;

  assign item.mode          = in_tuser;
  assign item.row           = in_tdata[1:0];
  assign item.column        = in_tdata[9:2];
  assign item.command_byte  = in_tdata[17:10];
  assign item.string_length = in_tdata[23:18];
  assign item.char_index    = in_tdata[28:24];
  assign item.char_value    = in_tdata[36:29];

  // The output register empties or is taken in the same cycle, so the input never stalls
  // on its own account.
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  clcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (accept),
    .item      (item),
    .upd       (upd),
    .ram       (ram)
  );

  clcd_ram #(
    .WIDTH (8),
    .DEPTH (clcd_pkg::CHAR_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .re    (ram.re),
    .raddr (ram.raddr),
    .rdata (ram_rdata)
  );

  // The read data stays put until the next store read, which only comes with a new item,
  // so the data lines can be resolved from it while the result waits.
  assign pins_now = ram_sel_r ? ram_rdata : data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      data_r      <= '0;
      ram_sel_r   <= 1'b0;
    end else begin
      if (accept) begin
        out_valid_r <= 1'b1;
        data_r      <= upd.data_we ? upd.data : pins_now;
        ram_sel_r   <= upd.data_ram;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rs_r    <= upd.rs;
      en_r    <= upd.en;
      phase_r <= upd.phase;
      busy_r  <= upd.busy;
      taken_r <= upd.taken;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, taken_r, busy_r, phase_r, en_r, rs_r, pins_now};

endmodule
